/* rtl/sba_pkg.sv */
package sba_pkg;

  localparam int KIND_W = 2;
  localparam int PID_W  = 2;
  localparam int SEG_W  = 4;
  localparam int SIZE_W = 13;
  localparam int ADDR_W = 12;

  // Request kinds; the fourth code is refused.
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd2;

  typedef enum logic [1:0] {
    RES_REFUSE = 2'd0,
    RES_ACCESS = 2'd1,
    RES_ALLOC  = 2'd2,
    RES_FREE   = 2'd3
  } res_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic seg_read;
    logic walk_start;
    logic walk_en;
    logic mark_step;
    logic commit_alloc;
    logic commit_free;
    logic finish;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic refuse;
    logic is_alloc;
    logic is_free;
    logic alloc_bad;
    logic held;
    logic walk_hit;
    logic walk_fail;
    logic mark_last;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/sba_if.sv */
interface sba_req_if;
  logic                           valid;
  logic                           ready;
  logic [sba_pkg::KIND_W-1:0]     kind;
  logic [sba_pkg::PID_W-1:0]      process_id;
  logic [sba_pkg::SEG_W-1:0]      segment;
  logic [sba_pkg::SIZE_W-1:0]     size_bytes;
  logic [sba_pkg::SIZE_W-1:0]     offset;

  modport source (output valid, kind, process_id, segment, size_bytes, offset, input ready);
  modport sink   (input valid, kind, process_id, segment, size_bytes, offset, output ready);
endinterface

interface sba_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           ok;
  logic [sba_pkg::ADDR_W-1:0]     base_address;
  logic [sba_pkg::SIZE_W-1:0]     segment_size;

  modport source (output valid, ok, base_address, segment_size, input ready);
  modport sink   (input valid, ok, base_address, segment_size, output ready);
endinterface

/* rtl/sba_datapath.sv */
module sba_datapath #(
  parameter int NUM_BLOCKS        = 64,
  parameter int BLOCK_BYTES       = 64,
  parameter int MAX_SEGMENT_BYTES = 4096,
  parameter int NUM_SEGMENTS      = 16,
  parameter int NUM_PROCESSES     = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sba_pkg::KIND_W-1:0]    kind,
  input  logic [sba_pkg::PID_W-1:0]     process_id,
  input  logic [sba_pkg::SEG_W-1:0]     segment,
  input  logic [sba_pkg::SIZE_W-1:0]    size_bytes,
  input  logic [sba_pkg::SIZE_W-1:0]    offset,
  input  logic                          rsp_ready,
  output logic                          rsp_valid,
  output logic                          ok,
  output logic [sba_pkg::ADDR_W-1:0]    base_address,
  output logic [sba_pkg::SIZE_W-1:0]    segment_size,
  input  sba_pkg::cmd_t                 cmd,
  output sba_pkg::sts_t                 sts
);

  localparam int TABLE_DEPTH = NUM_PROCESSES * NUM_SEGMENTS;
  localparam int BW          = $clog2(NUM_BLOCKS);
  localparam int SW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CLR_N       = (NUM_BLOCKS > TABLE_DEPTH) ? NUM_BLOCKS : TABLE_DEPTH;
  localparam int CW          = $clog2(CLR_N);
  localparam int RW          = $clog2(8191 + BLOCK_BYTES + 1);
  localparam int SZ          = sba_pkg::SIZE_W;

  typedef struct packed {
    logic used;
    logic head;
    logic tail;
  } blk_t;

  typedef struct packed {
    logic [BW-1:0] base;
    logic [SZ-1:0] size;
  } seg_t;

  blk_t blk_mem [NUM_BLOCKS];
  seg_t seg_mem [TABLE_DEPTH];

  logic [sba_pkg::KIND_W-1:0] req_kind;
  logic [sba_pkg::PID_W-1:0]  req_pid;
  logic [sba_pkg::SEG_W-1:0]  req_seg;
  logic [SZ-1:0]              req_size;
  logic [SZ-1:0]              req_offset;
  logic [SW-1:0]              slot;

  seg_t          seg_rd;
  blk_t          blk_rd;
  logic [BW-1:0] blk_rd_idx;
  logic          blk_rd_vld;
  logic [BW:0]   scan_idx;
  logic [RW-1:0] run_bytes;
  logic [BW-1:0] run_start;
  logic          first;
  logic [BW-1:0] base_blk;
  logic [BW-1:0] end_blk;
  logic [BW-1:0] mark_idx;
  logic [CW-1:0] clr_idx;

  logic          is_alloc;
  logic          is_free;
  logic [RW-1:0] run_next;
  logic [BW-1:0] start_next;
  logic          at_last;
  logic          hit_a;
  logic          fail_a;
  logic          hit_f;
  logic          fail_f;
  logic          hit;
  logic          fail;
  logic          issue;
  logic          blk_we;
  logic [BW-1:0] blk_waddr;
  blk_t          blk_wdata;
  logic          seg_we;
  logic [SW-1:0] seg_waddr;
  seg_t          seg_wdata;
  logic [31:0]   base_prod;

  assign is_alloc = (req_kind == sba_pkg::KIND_ALLOC);
  assign is_free  = (req_kind == sba_pkg::KIND_FREE);

  // Scan step: reset the run on a used block, else grow it by one block.
  assign run_next   = blk_rd.used ? '0 : run_bytes + RW'(BLOCK_BYTES);
  assign start_next = (run_bytes == '0) ? blk_rd_idx : run_start;
  assign at_last    = (blk_rd_idx == BW'(NUM_BLOCKS - 1));
  assign hit_a      = blk_rd_vld && !blk_rd.used && (run_next >= RW'(req_size));
  assign fail_a     = blk_rd_vld && !hit_a && at_last;
  assign fail_f     = blk_rd_vld && first && !blk_rd.head;
  assign hit_f      = blk_rd_vld && !fail_f && (blk_rd.tail || at_last);
  assign hit        = is_alloc ? hit_a : hit_f;
  assign fail       = is_alloc ? fail_a : fail_f;
  assign issue      = cmd.walk_en && !hit && !fail && (int'(scan_idx) < NUM_BLOCKS);

  always_comb begin
    blk_we    = 1'b0;
    blk_waddr = mark_idx;
    blk_wdata = '0;
    if (cmd.clr_step) begin
      blk_we    = (int'(clr_idx) < NUM_BLOCKS);
      blk_waddr = clr_idx[BW-1:0];
    end else if (cmd.mark_step) begin
      blk_we    = 1'b1;
      blk_wdata = '{used: 1'b1, head: (mark_idx == base_blk), tail: (mark_idx == end_blk)};
    end else if (cmd.walk_en && is_free && blk_rd_vld && !fail_f) begin
      blk_we    = 1'b1;
      blk_waddr = blk_rd_idx;
    end
  end

  always_comb begin
    seg_we    = 1'b0;
    seg_waddr = slot;
    seg_wdata = '0;
    if (cmd.clr_step) begin
      seg_we    = (int'(clr_idx) < TABLE_DEPTH);
      seg_waddr = clr_idx[SW-1:0];
    end else if (cmd.commit_alloc) begin
      seg_we    = 1'b1;
      seg_wdata = '{base: base_blk, size: req_size};
    end else if (cmd.commit_free) begin
      seg_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    if (issue) begin
      blk_rd <= blk_mem[scan_idx[BW-1:0]];
    end
    if (seg_we) begin
      seg_mem[seg_waddr] <= seg_wdata;
    end
    if (cmd.seg_read) begin
      seg_rd <= seg_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind   <= kind;
      req_pid    <= process_id;
      req_seg    <= segment;
      req_size   <= size_bytes;
      req_offset <= offset;
      slot       <= SW'(int'(process_id) * NUM_SEGMENTS + int'(segment));
    end
    if (cmd.walk_start) begin
      scan_idx  <= is_alloc ? '0 : {1'b0, seg_rd.base};
      run_bytes <= '0;
      first     <= 1'b1;
    end else begin
      if (issue) begin
        scan_idx   <= scan_idx + 1'b1;
        blk_rd_idx <= scan_idx[BW-1:0];
      end
      if (blk_rd_vld && cmd.walk_en) begin
        first     <= 1'b0;
        run_bytes <= run_next;
        run_start <= start_next;
      end
    end
    if (cmd.walk_en && is_alloc && hit_a) begin
      base_blk <= start_next;
      end_blk  <= blk_rd_idx;
      mark_idx <= start_next;
    end else if (cmd.mark_step) begin
      mark_idx <= mark_idx + 1'b1;
    end
    if (cmd.finish) begin
      case (cmd.res)
        sba_pkg::RES_ACCESS: begin
          ok           <= (seg_rd.size != '0) && (req_offset <= seg_rd.size);
          base_address <= '0;
          segment_size <= '0;
        end
        sba_pkg::RES_ALLOC: begin
          ok           <= 1'b1;
          base_address <= base_prod[sba_pkg::ADDR_W-1:0];
          segment_size <= req_size;
        end
        sba_pkg::RES_FREE: begin
          ok           <= 1'b1;
          base_address <= '0;
          segment_size <= '0;
        end
        default: begin
          ok           <= 1'b0;
          base_address <= '0;
          segment_size <= '0;
        end
      endcase
    end
  end

  assign base_prod = 32'(base_blk) * 32'(BLOCK_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_rd_vld <= 1'b0;
      clr_idx    <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      blk_rd_vld <= issue;
      if (cmd.clr_step) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.clr_last  = (clr_idx == CW'(CLR_N - 1));
    sts.refuse    = (int'(req_pid) >= NUM_PROCESSES) || (int'(req_seg) >= NUM_SEGMENTS) ||
                    !(is_alloc || is_free || (req_kind == sba_pkg::KIND_ACCESS));
    sts.is_alloc  = is_alloc;
    sts.is_free   = is_free;
    sts.held      = (seg_rd.size != '0);
    sts.alloc_bad = (req_size == '0) || (int'(req_size) > MAX_SEGMENT_BYTES) ||
                    (seg_rd.size != '0);
    sts.walk_hit  = hit;
    sts.walk_fail = fail;
    sts.mark_last = (mark_idx == end_blk);
    sts.out_busy  = rsp_valid && !rsp_ready;
  end

endmodule

/* rtl/sba_ctrl.sv */
module sba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sba_pkg::sts_t sts,
  output sba_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_LOOKUP = 8'b0000_0100,
    ST_CHECK  = 8'b0000_1000,
    ST_WALK   = 8'b0001_0000,
    ST_MARK   = 8'b0010_0000,
    ST_COMMIT = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t        state;
  state_t        state_next;
  sba_pkg::res_t res;
  sba_pkg::res_t res_next;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd        = '0;
    cmd.res    = res;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts.refuse) begin
          res_next   = sba_pkg::RES_REFUSE;
          state_next = ST_DONE;
        end else begin
          cmd.seg_read = 1'b1;
          state_next   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.is_alloc) begin
          if (sts.alloc_bad) begin
            res_next   = sba_pkg::RES_REFUSE;
            state_next = ST_DONE;
          end else begin
            cmd.walk_start = 1'b1;
            state_next     = ST_WALK;
          end
        end else if (sts.is_free) begin
          if (!sts.held) begin
            res_next   = sba_pkg::RES_REFUSE;
            state_next = ST_DONE;
          end else begin
            cmd.walk_start = 1'b1;
            state_next     = ST_WALK;
          end
        end else begin
          res_next   = sba_pkg::RES_ACCESS;
          state_next = ST_DONE;
        end
      end
      ST_WALK: begin
        cmd.walk_en = 1'b1;
        if (sts.walk_fail) begin
          res_next   = sba_pkg::RES_REFUSE;
          state_next = ST_DONE;
        end else if (sts.walk_hit) begin
          state_next = sts.is_alloc ? ST_MARK : ST_COMMIT;
        end
      end
      ST_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.is_alloc) begin
          cmd.commit_alloc = 1'b1;
          res_next         = sba_pkg::RES_ALLOC;
        end else begin
          cmd.commit_free = 1'b1;
          res_next        = sba_pkg::RES_FREE;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      res   <= sba_pkg::RES_REFUSE;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  ast_capture_to_lookup: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_LOOKUP))
    else $error("request capture did not lead to table lookup");

  ast_mark_to_commit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK && sts.mark_last) |=> (state == ST_COMMIT))
    else $error("marking pass did not end in commit");

  ast_done_release: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !sts.out_busy) |=> (state == ST_IDLE))
    else $error("result not handed to output register");

  ast_commit_res: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT) |=> (state == ST_DONE && res != sba_pkg::RES_REFUSE))
    else $error("commit produced a refusal");

endmodule

/* rtl/segment_block_allocator.sv */
// Segment block allocator: first-fit contiguous allocation of fixed-size
// blocks to per-process segment slots.
//
// Channels: req (sink) carries kind, process_id, segment, size_bytes and
// offset; rsp (source) returns one result per request: ok, base_address and
// segment_size. A transfer happens on a clock edge with valid and ready high.
//
// Sequence: a request is taken, then looked up and checked. Access and refusals
// of bad requests finish there, an unknown kind already at lookup. Allocate
// scans the block bitmap one block per cycle through the block memory read
// port, then marks one block per cycle for the blocks granted; free walks its
// blocks one per cycle. A failing scan or walk is refused; one request is
// in service at a time.
//
// Reset: rst (synchronous) starts a clearing pass that zeroes the bitmap and
// segment table; req.ready stays low until it ends.
// Stall: the result sits in an output register; a new request is taken
// while it waits, but the next result holds until rsp.ready takes the last.
module segment_block_allocator #(
  parameter int NUM_BLOCKS        = 64,
  parameter int BLOCK_BYTES       = 64,
  parameter int MAX_SEGMENT_BYTES = 4096,
  parameter int NUM_SEGMENTS      = 16,
  parameter int NUM_PROCESSES     = 4
) (
  input logic       clk,
  input logic       rst,
  sba_req_if.sink   req,
  sba_rsp_if.source rsp
);

  sba_pkg::cmd_t cmd;
  sba_pkg::sts_t sts;

  // Controller: sequences clear, lookup, scan/walk, mark and commit.
  sba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: request registers, block and segment memories, output register.
  sba_datapath #(
    .NUM_BLOCKS        (NUM_BLOCKS),
    .BLOCK_BYTES       (BLOCK_BYTES),
    .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES),
    .NUM_SEGMENTS      (NUM_SEGMENTS),
    .NUM_PROCESSES     (NUM_PROCESSES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .kind         (req.kind),
    .process_id   (req.process_id),
    .segment      (req.segment),
    .size_bytes   (req.size_bytes),
    .offset       (req.offset),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .ok           (rsp.ok),
    .base_address (rsp.base_address),
    .segment_size (rsp.segment_size),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

/* sim/tb_segment_block_allocator.sv */
module tb_segment_block_allocator;

  localparam int NUM_BLOCKS      = 64;
  localparam int BLOCK_BYTES     = 64;
  localparam int MAX_SEG_BYTES   = 4096;
  localparam int NUM_SEGMENTS    = 16;
  localparam int NUM_PROCESSES   = 4;
  localparam int SLOTS           = NUM_PROCESSES * NUM_SEGMENTS;

  typedef logic [sba_pkg::KIND_W-1:0] kind_t;
  typedef logic [sba_pkg::PID_W-1:0]  pid_t;
  typedef logic [sba_pkg::SEG_W-1:0]  seg_t;
  typedef logic [sba_pkg::SIZE_W-1:0] size_t;
  typedef logic [sba_pkg::ADDR_W-1:0] addr_t;

  // The fourth request code has no name in the package; the block refuses it.
  localparam kind_t KIND_UNKNOWN = 2'd3;

  localparam int RANDOM_ITEMS    = 630;
  localparam int HOLD_OFF_AFTER  = 200;   // results seen before the long sink stall
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int SETTLE_CYCLES   = 2 * NUM_BLOCKS + 32;
  localparam int RUN_LIMIT       = 10_000_000;

  typedef struct packed {
    kind_t kind;
    pid_t  process_id;
    seg_t  segment;
    size_t size_bytes;
    size_t offset;
  } request_t;

  typedef struct packed {
    logic  ok;
    addr_t base_address;
    size_t segment_size;
  } grant_t;

  // One directed row: the request, whether the expected grant is typed in,
  // and that grant. Rows with typed == 0 take the predicted grant.
  typedef struct packed {
    request_t rq;
    logic     typed;
    grant_t   want;
  } stim_row_t;

  localparam int NUM_DIRECTED = 24;
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // nothing held after reset: access and free are refused
    '{'{sba_pkg::KIND_ACCESS, 2'd0, 4'd0, 13'd0, 13'd0}, 1'b1, '{1'b0, 12'd0, 13'd0}},
    '{'{sba_pkg::KIND_FREE, 2'd0, 4'd0, 13'd0, 13'd0}, 1'b1, '{1'b0, 12'd0, 13'd0}},
    // bad sizes: zero, one byte over the maximum, all ones
    '{'{sba_pkg::KIND_ALLOC, 2'd0, 4'd0, 13'd0, 13'd0}, 1'b1, '{1'b0, 12'd0, 13'd0}},
    '{'{sba_pkg::KIND_ALLOC, 2'd0, 4'd0, 13'd4097, 13'd0}, 1'b1, '{1'b0, 12'd0, 13'd0}},
    '{'{sba_pkg::KIND_ALLOC, 2'd1, 4'd7, 13'd8191, 13'd0}, 1'b1, '{1'b0, 12'd0, 13'd0}},
    // the whole memory in one segment, then no room for even one byte
    '{'{sba_pkg::KIND_ALLOC, 2'd3, 4'd15, 13'd4096, 13'd0}, 1'b1, '{1'b1, 12'd0, 13'd4096}},
    '{'{sba_pkg::KIND_ALLOC, 2'd0, 4'd0, 13'd1, 13'd0}, 1'b1, '{1'b0, 12'd0, 13'd0}},
    // access at the size passes, one past it and far past it fail
    '{'{sba_pkg::KIND_ACCESS, 2'd3, 4'd15, 13'd0, 13'd4096}, 1'b1, '{1'b1, 12'd0, 13'd0}},
    '{'{sba_pkg::KIND_ACCESS, 2'd3, 4'd15, 13'd0, 13'd4097}, 1'b1, '{1'b0, 12'd0, 13'd0}},
    '{'{sba_pkg::KIND_ACCESS, 2'd3, 4'd15, 13'd0, 13'd8191}, 1'b1, '{1'b0, 12'd0, 13'd0}},
    // held segment cannot be allocated again; free twice
    '{'{sba_pkg::KIND_ALLOC, 2'd3, 4'd15, 13'd64, 13'd0}, 1'b1, '{1'b0, 12'd0, 13'd0}},
    '{'{sba_pkg::KIND_FREE, 2'd3, 4'd15, 13'd0, 13'd0}, 1'b1, '{1'b1, 12'd0, 13'd0}},
    '{'{sba_pkg::KIND_FREE, 2'd3, 4'd15, 13'd0, 13'd0}, 1'b1, '{1'b0, 12'd0, 13'd0}},
    // rounding up: one byte takes a block, 65 bytes take two
    '{'{sba_pkg::KIND_ALLOC, 2'd0, 4'd0, 13'd1, 13'd0}, 1'b1, '{1'b1, 12'd0, 13'd1}},
    '{'{sba_pkg::KIND_ALLOC, 2'd1, 4'd1, 13'd65, 13'd0}, 1'b1, '{1'b1, 12'd64, 13'd65}},
    '{'{sba_pkg::KIND_ALLOC, 2'd2, 4'd2, 13'd64, 13'd0}, 1'b0, '0},
    // open a hole at the bottom and let first fit take it
    '{'{sba_pkg::KIND_FREE, 2'd0, 4'd0, 13'd0, 13'd0}, 1'b1, '{1'b1, 12'd0, 13'd0}},
    '{'{sba_pkg::KIND_ALLOC, 2'd0, 4'd1, 13'd64, 13'd0}, 1'b0, '0},
    '{'{sba_pkg::KIND_ALLOC, 2'd0, 4'd2, 13'd128, 13'd0}, 1'b0, '0},
    '{'{KIND_UNKNOWN, 2'd3, 4'd15, 13'd8191, 13'd8191}, 1'b1, '{1'b0, 12'd0, 13'd0}},
    '{'{sba_pkg::KIND_ACCESS, 2'd1, 4'd1, 13'd0, 13'd0}, 1'b0, '0},
    '{'{sba_pkg::KIND_ACCESS, 2'd1, 4'd1, 13'd0, 13'd65}, 1'b0, '0},
    '{'{sba_pkg::KIND_ACCESS, 2'd1, 4'd1, 13'd0, 13'd66}, 1'b0, '0},
    '{'{sba_pkg::KIND_ALLOC, 2'd2, 4'd3, 13'd4096, 13'd0}, 1'b1, '{1'b0, 12'd0, 13'd0}}
  };

  logic clk;
  logic rst;

  sba_req_if req_ch ();
  sba_rsp_if rsp_ch ();

  segment_block_allocator #(
    .NUM_BLOCKS       (NUM_BLOCKS),
    .BLOCK_BYTES      (BLOCK_BYTES),
    .MAX_SEGMENT_BYTES(MAX_SEG_BYTES),
    .NUM_SEGMENTS     (NUM_SEGMENTS),
    .NUM_PROCESSES    (NUM_PROCESSES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow allocator state: block bitmap with run marks, per-slot table.
  // Two-state storage starts at zero, matching the cleared block.
  bit                         blk_used  [NUM_BLOCKS];
  bit                         blk_begin [NUM_BLOCKS];
  bit                         blk_end   [NUM_BLOCKS];
  bit [5:0]                   slot_base [SLOTS];
  bit [sba_pkg::SIZE_W-1:0]   slot_bytes[SLOTS];

  grant_t expected_grants[$];
  int     mismatch_count = 0;
  int     results_seen   = 0;
  grant_t oldest_grant;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t (result %0d): %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  // Apply one request to the shadow state and return the grant it produces.
  function automatic grant_t apply_request(input request_t r);
    grant_t g;
    int     slot;
    int     nblk;
    int     run;
    int     first;
    int     i;
    bit     found;
    bit     last;
    g = '0;
    if (int'(r.process_id) >= NUM_PROCESSES || int'(r.segment) >= NUM_SEGMENTS) return g;
    slot = int'(r.process_id) * NUM_SEGMENTS + int'(r.segment);
    case (r.kind)
      sba_pkg::KIND_ALLOC: begin
        if (r.size_bytes == '0 || int'(r.size_bytes) > MAX_SEG_BYTES ||
            slot_bytes[slot] != '0) return g;
        nblk = (int'(r.size_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        if (nblk > NUM_BLOCKS) return g;
        // first fit: stop at the lowest run of nblk free blocks
        run   = 0;
        first = 0;
        found = 1'b0;
        for (i = 0; i < NUM_BLOCKS && !found; i++) begin
          run = blk_used[i] ? 0 : run + 1;
          if (run == nblk) begin
            first = i + 1 - nblk;
            found = 1'b1;
          end
        end
        if (!found) return g;
        for (i = first; i < first + nblk; i++) begin
          blk_used[i]  = 1'b1;
          blk_begin[i] = (i == first);
          blk_end[i]   = (i == first + nblk - 1);
        end
        slot_base[slot]  = 6'(first);
        slot_bytes[slot] = r.size_bytes;
        g.ok           = 1'b1;
        g.base_address = addr_t'(first * BLOCK_BYTES);
        g.segment_size = r.size_bytes;
      end
      sba_pkg::KIND_FREE: begin
        i = int'(slot_base[slot]);
        if (slot_bytes[slot] == '0 || !blk_begin[i]) return g;
        // release up to the end mark, or to the last block if none is found
        last = 1'b0;
        while (!last) begin
          last         = blk_end[i] || i == NUM_BLOCKS - 1;
          blk_used[i]  = 1'b0;
          blk_begin[i] = 1'b0;
          blk_end[i]   = 1'b0;
          i++;
        end
        slot_base[slot]  = '0;
        slot_bytes[slot] = '0;
        g.ok             = 1'b1;
      end
      sba_pkg::KIND_ACCESS: g.ok = slot_bytes[slot] != '0 && r.offset <= slot_bytes[slot];
      default: ;
    endcase
    return g;
  endfunction

  // Mostly zero, sometimes a few cycles, rarely a long stretch.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(4, 1);
    if (roll < 97) return $urandom_range(20, 5);
    return $urandom_range(90, 30);
  endfunction

  function automatic size_t random_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return size_t'($urandom_range(256, 1));
    if (roll < 85) return size_t'($urandom_range(1024, 257));
    if (roll < 92) return size_t'($urandom_range(MAX_SEG_BYTES, 1025));
    case ($urandom_range(5))
      0:       return '0;
      1:       return size_t'(MAX_SEG_BYTES);
      2:       return size_t'(BLOCK_BYTES);
      3:       return size_t'(BLOCK_BYTES + 1);
      4:       return size_t'($urandom_range(8191, MAX_SEG_BYTES + 1));
      default: return size_t'($urandom);
    endcase
  endfunction

  // Build a request that mostly makes sense against the current shadow state:
  // frees and accesses usually aim at held slots, offsets sit near the size.
  function automatic request_t random_request();
    request_t   r;
    int         held[$];
    int         roll;
    logic [5:0] pick;
    size_t      held_bytes;
    for (int s = 0; s < SLOTS; s++)
      if (slot_bytes[s] != '0) held.push_back(s);
    r.kind       = sba_pkg::KIND_ALLOC;
    r.process_id = pid_t'($urandom);
    r.segment    = seg_t'($urandom);
    r.size_bytes = size_t'($urandom);
    r.offset     = size_t'($urandom);
    pick         = {r.process_id, r.segment};
    if (held.size() > 0) pick = 6'(held[$urandom_range(held.size() - 1)]);
    held_bytes = slot_bytes[pick];
    roll = $urandom_range(99);
    if (roll < 45) begin
      r.size_bytes = random_size();
    end else if (roll < 70) begin
      r.kind = sba_pkg::KIND_FREE;
      if (roll < 67) {r.process_id, r.segment} = pick;
    end else if (roll < 94) begin
      r.kind = sba_pkg::KIND_ACCESS;
      if (roll < 90) {r.process_id, r.segment} = pick;
      case ($urandom_range(4))
        0:       r.offset = held_bytes;
        1:       r.offset = held_bytes + 1'b1;
        2:       r.offset = held_bytes - 1'b1;
        3:       r.offset = size_t'($urandom_range(int'(held_bytes)));
        default: ;
      endcase
    end else begin
      r.kind = kind_t'($urandom_range(3));
    end
    return r;
  endfunction

  // Offer one request after an optional idle gap, hold it until the block
  // takes it, then predict and queue its grant. Call at a rising edge.
  task automatic issue(input request_t r, input bit typed, input grant_t want,
                       input int gap);
    grant_t predicted;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= r.kind;
    req_ch.process_id <= r.process_id;
    req_ch.segment    <= r.segment;
    req_ch.size_bytes <= r.size_bytes;
    req_ch.offset     <= r.offset;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_request(r);
    expected_grants.push_back(typed ? want : predicted);
  endtask

  // Request side: reset, directed table, random traffic, drain, verdict.
  initial begin
    int gap;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.kind       <= '0;
    req_ch.process_id <= '0;
    req_ch.segment    <= '0;
    req_ch.size_bytes <= '0;
    req_ch.offset     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // The block runs its clearing pass now; issue simply waits on ready.
    foreach (DIRECTED_ROWS[n])
      issue(DIRECTED_ROWS[n].rq, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].want, pick_gap());

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Halfway through, drop valid and hold until every grant is back.
      if (n == RANDOM_ITEMS / 2) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_grants.size() != 0);
      end
      // One stretch in four runs back to back with no idle cycles.
      gap = ((n / 64) % 4 == 1) ? 0 : pick_gap();
      issue(random_request(), 1'b0, '0, gap);
    end

    req_ch.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    // Keep watching long enough for a stray extra result to show up.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Result side: random ready bursts and stalls, plus one long hold-off once
  // enough results have come, so the block backs up and stalls its input.
  initial begin
    int  burst;
    int  stall;
    bit  held_off;
    held_off = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      burst = ($urandom_range(19) == 0) ? $urandom_range(300, 100) : $urandom_range(30, 1);
      stall = pick_gap();
      if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        stall    = HOLD_OFF_CYCLES;
      end
      @(posedge clk);
      rsp_ch.ready <= 1'b1;
      repeat (burst) @(posedge clk);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Compare each accepted result against the oldest outstanding grant.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_grants.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        oldest_grant = expected_grants.pop_front();
        if (rsp_ch.ok !== oldest_grant.ok)
          report_mismatch($sformatf("ok got %0b want %0b", rsp_ch.ok, oldest_grant.ok));
        if (rsp_ch.base_address !== oldest_grant.base_address)
          report_mismatch($sformatf("base_address got %0d want %0d",
                                    rsp_ch.base_address, oldest_grant.base_address));
        if (rsp_ch.segment_size !== oldest_grant.segment_size)
          report_mismatch($sformatf("segment_size got %0d want %0d",
                                    rsp_ch.segment_size, oldest_grant.segment_size));
      end
    end
  end

endmodule
